@@ rtl/core/cnfs_pkg.sv @@
// shared types, constants and the character classifier of the n-gram scorer
package cnfs_pkg;

	localparam int SUM_W   = 48;
	localparam int LEN_W   = 16;
	localparam int SCORE_W = 33;
	localparam int CODE_W  = 6;
	localparam int QUO_W   = 34;

	localparam logic [CODE_W-1:0] SEP_CODE    = 6'd63;
	localparam logic [CODE_W-1:0] USCORE_CODE = 6'd62;

	localparam logic OP_TRAIN = 1'b0;
	localparam logic OP_SCORE = 1'b1;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_MODEL_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG    = 2'd3;

	typedef struct packed {
		logic       op;
		logic [7:0] char_code;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [SUM_W-1:0]   count_sum;
		logic [LEN_W-1:0]   word_length;
		logic [1:0]         status;
	} out_item_t;

	// control bits of one queued job
	typedef struct packed {
		logic op;
		logic sep;
		logic last;
	} job_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} back_state_t;

	// byte to 6-bit class code
	function automatic logic [CODE_W-1:0] classify(input logic [7:0] b);
		logic [CODE_W-1:0] c;
		c = SEP_CODE;
		if (b >= 8'h30 && b <= 8'h39) begin
			c = CODE_W'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h5a) begin
			c = CODE_W'(b - 8'h41 + 8'd10);
		end else if (b >= 8'h61 && b <= 8'h7a) begin
			c = CODE_W'(b - 8'h61 + 8'd36);
		end else if (b == 8'h5f) begin
			c = USCORE_CODE;
		end
		return c;
	endfunction

endpackage

@@ rtl/core/char_ngram_frequency_scorer.sv @@
// top level of the character n-gram frequency scorer
//
// Input queue: an item (op, char_code, last) transfers when push is high and
// full is low. op 0 trains the histogram on the character, op 1 adds the
// character to the word being scored. Result queue: while empty is low the
// waiting result sits on result and transfers when pop is high.
// Train characters and non-final score characters take one histogram ram
// read in the back end, then the count write-back and word update.
// The final character of a scored word adds a shift-add multiply of total
// count by word length, a restoring divide and the result register load.
// With an empty model or an over-long word the multiply and divide are
// skipped and the result register is loaded directly.
// A four-entry job queue lets the front accept characters while the back
// works; a result waiting to be popped holds the back end only when the next
// word finishes. After reset the histogram ram is swept to zero, one entry a
// cycle, all 64^ORDER entries (262144 at ORDER 3); full stays high until then.
module char_ngram_frequency_scorer
	import cnfs_pkg::*;
#(
	parameter int ORDER       = 3,
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  item,
	output logic      full,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam int AW = CODE_W * ORDER;

	logic                   clearing;
	logic                   q_valid;
	logic                   q_pop;
	job_ctl_t               q_ctl;
	logic [AW-1:0]          q_addr;
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	// classification and job queue
	cnfs_front #(.ORDER(ORDER)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_ctl    (q_ctl),
		.q_addr   (q_addr)
	);

	// histogram update and scoring
	cnfs_back #(.ORDER(ORDER), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_ctl     (q_ctl),
		.q_addr    (q_addr),
		.clearing  (clearing),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// n-gram histogram
	cnfs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2 ** AW)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

@@ rtl/core/cnfs_ram.sv @@
// generic single-port ram with registered read
module cnfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/cnfs_front.sv @@
// front end: classify characters, keep the rolling index, queue jobs
module cnfs_front
	import cnfs_pkg::*;
#(
	parameter int ORDER = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              item,
	output logic                  full,
	input  logic                  clearing,
	output logic                  q_valid,
	input  logic                  q_pop,
	output job_ctl_t              q_ctl,
	output logic [CODE_W*ORDER-1:0] q_addr
);

	localparam int AW  = CODE_W * ORDER;
	localparam int EW  = $bits(job_ctl_t) + AW;
	localparam int QD  = 4;
	localparam int QPW = $clog2(QD);

	logic [AW-1:0]  idx_q;
	logic [EW-1:0]  entry_q [QD];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   cnt_q;

	logic              accept;
	logic [CODE_W-1:0] code;
	logic              sep;
	logic [AW-1:0]     next_addr;
	job_ctl_t          ctl;

	assign full   = clearing || (cnt_q == (QPW+1)'(QD));
	assign accept = push && !full;

	// classify and advance the rolling index
	always_comb begin
		code      = classify(item.char_code);
		sep       = (code == SEP_CODE);
		next_addr = {idx_q[AW-CODE_W-1:0], code};
		if (item.op == OP_TRAIN && sep) begin
			next_addr = '1;
		end
		ctl.op   = item.op;
		ctl.sep  = sep;
		ctl.last = item.last;
	end

	// rolling index, reset to all separators at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '1;
		end else if (accept) begin
			idx_q <= item.last ? '1 : next_addr;
		end
	end

	// job queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= {ctl, next_addr};
		end
	end

	// job queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPW+1)'(accept) - (QPW+1)'(q_pop);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign {q_ctl, q_addr} = entry_q[rd_ptr_q];

endmodule

@@ rtl/core/cnfs_back.sv @@
// back end: histogram update, word accumulation, score division, result register
module cnfs_back
	import cnfs_pkg::*;
#(
	parameter int ORDER       = 3,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  job_ctl_t                q_ctl,
	input  logic [CODE_W*ORDER-1:0] q_addr,
	output logic                    clearing,
	output logic                    ram_we,
	output logic [CODE_W*ORDER-1:0] ram_addr,
	output logic [COUNT_WIDTH-1:0]  ram_wdata,
	input  logic [COUNT_WIDTH-1:0]  ram_rdata,
	output logic                    empty,
	input  logic                    pop,
	output out_item_t               result
);

	localparam int AW    = CODE_W * ORDER;
	localparam int CW    = COUNT_WIDTH;
	localparam int PW    = CW + LEN_W;
	localparam int CMP_W = (PW + QUO_W - 1 > SUM_W + 32) ? PW + QUO_W - 1 : SUM_W + 32;
	localparam int SW    = ((CW > SUM_W) ? CW : SUM_W) + 1;
	localparam logic [SW-1:0]      SUM_MAX_X = SW'({SUM_W{1'b1}});
	localparam logic [QUO_W-1:0]   ONE_Q32   = QUO_W'(64'h1_0000_0000);
	localparam logic [5:0]         MUL_LAST  = 6'(LEN_W - 1);
	localparam logic [5:0]         DIV_LAST  = 6'(QUO_W - 1);

	back_state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	job_ctl_t          ctl_q;
	logic [AW-1:0]     addr_q;
	logic [CW-1:0]     total_q;
	logic [SUM_W-1:0]  sum_q;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [PW-1:0]     mcand_q;
	logic [LEN_W-1:0]  mplier_q;
	logic [PW-1:0]     acc_q;
	logic [5:0]        step_q;
	logic [CMP_W-1:0]  rem_q;
	logic [CMP_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              cnt_full;
	logic [LEN_W-1:0]  len_next;
	logic              ovf_next;
	logic              add_en;
	logic [SW-1:0]     sum_ext;
	logic [SUM_W-1:0]  sum_next;
	logic [PW-1:0]     acc_next;
	logic              ge;
	logic              out_free;

	// word accumulation for a score character
	always_comb begin
		cnt_full = &ram_rdata;
		ovf_next = ovf_q;
		len_next = len_q;
		if (len_q == '1) begin
			ovf_next = 1'b1;
		end else begin
			len_next = len_q + 1'b1;
		end
		add_en   = ovf_next || (len_next >= LEN_W'(ORDER)) || ctl_q.last;
		sum_ext  = SW'(sum_q) + SW'(ram_rdata);
		sum_next = sum_q;
		if (add_en) begin
			sum_next = (sum_ext > SUM_MAX_X) ? SUM_MAX_X[SUM_W-1:0] : sum_ext[SUM_W-1:0];
		end
		acc_next = mplier_q[0] ? acc_q + mcand_q : acc_q;
		ge       = (rem_q >= dsh_q);
		out_free = !out_valid_q || pop;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (ctl_q.op == OP_SCORE && ctl_q.last) begin
					state_d = (total_q == '0 || ovf_next) ? ST_OUT : ST_MUL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				if (step_q == MUL_LAST) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == DIV_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: queue pop and ram port
	always_comb begin
		q_pop     = 1'b0;
		clearing  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = cnt_full ? ram_rdata : ram_rdata + 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				clearing  = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				q_pop    = q_valid;
				ram_addr = q_addr;
			end
			ST_READ: begin
				ram_we = (ctl_q.op == OP_TRAIN) && !ctl_q.sep;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			sum_q       <= '0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_READ) begin
				if (ctl_q.op == OP_TRAIN) begin
					sum_q <= '0;
					len_q <= '0;
					ovf_q <= 1'b0;
					if (!ctl_q.sep && total_q != '1) begin
						total_q <= total_q + 1'b1;
					end
				end else begin
					sum_q <= sum_next;
					len_q <= len_next;
					ovf_q <= ovf_next;
				end
			end
			if (state_q == ST_OUT && out_free) begin
				sum_q       <= '0;
				len_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers: job latch, shift-add multiply, restoring divide, result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			ctl_q  <= q_ctl;
			addr_q <= q_addr;
		end
		if (state_q == ST_READ) begin
			mcand_q  <= PW'(total_q);
			mplier_q <= len_next;
			acc_q    <= '0;
			step_q   <= '0;
		end
		if (state_q == ST_MUL) begin
			acc_q    <= acc_next;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			step_q   <= step_q + 1'b1;
			if (step_q == MUL_LAST) begin
				dsh_q  <= CMP_W'(acc_next) << (QUO_W - 1);
				rem_q  <= CMP_W'({sum_q, 32'b0});
				quo_q  <= '0;
				step_q <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q  <= {quo_q[QUO_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q + 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.count_sum   <= sum_q;
			out_q.word_length <= len_q;
			if (total_q == '0) begin
				out_q.score  <= '0;
				out_q.status <= STATUS_MODEL_EMPTY;
			end else if (ovf_q) begin
				out_q.score  <= '0;
				out_q.status <= STATUS_TOO_LONG;
			end else begin
				out_q.score  <= (quo_q > ONE_Q32) ? ONE_Q32[SCORE_W-1:0] : quo_q[SCORE_W-1:0];
				out_q.status <= STATUS_OK;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ rtl/core/cnfs_checker.sv @@
// port-level checker for the n-gram scorer and its bind
module cnfs_checker
	import cnfs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// a waiting result stays until it transfers
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// score never above one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.score <= 33'h1_0000_0000)
		else $error("score above 1.0");

	// empty model scores zero
	a_model_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == STATUS_MODEL_EMPTY |-> result.score == '0)
		else $error("empty model with nonzero score");

	// over-long word scores zero at saturated length
	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == STATUS_TOO_LONG
		|-> result.score == '0 && result.word_length == 16'hffff)
		else $error("over-long word result malformed");

endmodule

bind char_ngram_frequency_scorer cnfs_checker u_cnfs_checker (.*);
